// File: sv/i2cbc_pkg.sv
// Package: shared types, constants and helpers for the I2C bus-clear sequencer.
`timescale 1ns / 1ps
package i2cbc_pkg;

  // Width of the phase timer
  localparam int TIMER_WIDTH = 16;
  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

  // Field and register widths
  localparam int HALF_W  = 16;
  localparam int PULSE_W = 5;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSES  = 1'd1;

  // Register reset values
  localparam logic [HALF_W-1:0]  HALF_PERIOD_RST = 16'd5;
  localparam logic [PULSE_W-1:0] MAX_PULSES_RST  = 5'd16;

  // Status codes
  localparam logic [STAT_W-1:0] STATUS_NONE  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_STOP  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_ABORT = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_CHECK     = 3'd1,
    PH_CLK_LOW   = 3'd2,
    PH_CLK_HIGH  = 3'd3,
    PH_STOP_LOW  = 3'd4,
    PH_STOP_HOLD = 3'd5,
    PH_STOP_TAIL = 3'd6
  } phase_t;

  typedef struct packed {
    phase_t                   phase;
    logic [TIMER_WIDTH-1:0]   timer;
    logic [PULSE_W-1:0]       count;
  } seq_state_t;

  typedef struct packed {
    logic               scl_release;
    logic               sda_release;
    logic               busy_res;
    logic               done_res;
    logic [STAT_W-1:0]  status;
    logic [PULSE_W-1:0] pulses_sent;
  } seq_res_t;

  // Half-period reload value: zero acts as one, saturate to the timer range
  function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [HALF_W-1:0] hp);
    logic [31:0] v;
    v = {{(32-HALF_W){1'b0}}, hp};
    if (v == 32'd0) v = 32'd1;
    if (v > TIMER_MAX) v = TIMER_MAX;
    return v[TIMER_WIDTH-1:0];
  endfunction

endpackage

// File: sv/i2cbc_step.sv
// Next-state and result logic for one tick of the bus-clear sequence.
`timescale 1ns / 1ps
module i2cbc_step (
  input  i2cbc_pkg::seq_state_t             cur,
  input  logic                              start_req,
  input  logic                              scl_level,
  input  logic                              sda_level,
  input  logic [i2cbc_pkg::HALF_W-1:0]      half_period_ticks,
  input  logic [i2cbc_pkg::PULSE_W-1:0]     max_pulses,
  output i2cbc_pkg::seq_state_t             nxt,
  output i2cbc_pkg::seq_res_t               res
);
  import i2cbc_pkg::*;

  logic                   timed;
  logic [TIMER_WIDTH-1:0] timer_dec;
  logic                   expired;
  logic [TIMER_WIDTH-1:0] reload;
  logic                   more_pulse;
  logic                   done;
  logic [STAT_W-1:0]      status;

  // Timer counts down in the timed phases
  assign timed = (cur.phase == PH_CLK_LOW) || (cur.phase == PH_CLK_HIGH) ||
                 (cur.phase == PH_STOP_LOW) || (cur.phase == PH_STOP_HOLD) ||
                 (cur.phase == PH_STOP_TAIL);
  assign timer_dec = (timed && cur.timer != '0) ? cur.timer - 1'b1 : cur.timer;
  assign expired   = timed && (timer_dec == '0);
  assign reload    = timer_load(half_period_ticks);
  assign more_pulse = !sda_level && (cur.count < max_pulses);

  // Phase sequencing
  always_comb begin
    nxt       = cur;
    nxt.timer = timer_dec;
    done      = 1'b0;
    status    = STATUS_NONE;
    unique case (cur.phase)
      PH_IDLE: begin
        if (start_req) begin
          nxt.count = '0;
          nxt.phase = PH_CHECK;
          nxt.timer = '0;
        end
      end
      PH_CHECK: begin
        if (!scl_level) begin
          nxt.phase = PH_IDLE;
          nxt.timer = '0;
          done      = 1'b1;
          status    = STATUS_ABORT;
        end else if (more_pulse) begin
          nxt.count = cur.count + 1'b1;
          nxt.phase = PH_CLK_LOW;
          nxt.timer = reload;
        end else begin
          nxt.phase = PH_STOP_LOW;
          nxt.timer = reload;
        end
      end
      PH_CLK_LOW: begin
        if (expired) begin
          nxt.phase = PH_CLK_HIGH;
          nxt.timer = reload;
        end
      end
      PH_CLK_HIGH: begin
        if (expired) begin
          if (more_pulse) begin
            nxt.count = cur.count + 1'b1;
            nxt.phase = PH_CLK_LOW;
          end else begin
            nxt.phase = PH_STOP_LOW;
          end
          nxt.timer = reload;
        end
      end
      PH_STOP_LOW: begin
        if (expired) begin
          nxt.phase = PH_STOP_HOLD;
          nxt.timer = reload;
        end
      end
      PH_STOP_HOLD: begin
        if (expired) begin
          nxt.phase = PH_STOP_TAIL;
          nxt.timer = reload;
        end
      end
      PH_STOP_TAIL: begin
        if (expired) begin
          nxt.phase = PH_IDLE;
          nxt.timer = '0;
          done      = 1'b1;
          status    = STATUS_STOP;
        end
      end
      default: begin
        nxt.phase = PH_IDLE;
        nxt.timer = '0;
      end
    endcase
  end

  // Line drive and status view after the update
  assign res.scl_release = (nxt.phase != PH_CLK_LOW);
  assign res.sda_release = !((nxt.phase == PH_STOP_LOW) || (nxt.phase == PH_STOP_HOLD));
  assign res.busy_res    = (nxt.phase != PH_IDLE);
  assign res.done_res    = done;
  assign res.status      = status;
  assign res.pulses_sent = nxt.count;

endmodule

// File: sv/i2c_bus_clear_sequencer_core.sv
// Top level of the I2C bus-clear sequencer: tick register, sequence state, result register.
//
// Usage: each input request is one time tick carrying start_req and the sampled
// SCL/SDA levels. Each accepted request yields exactly one result request with
// the line drive (scl/sda release), busy, done, status and the pulse count.
// Channels: in_* and out_* use valid/ready; cfg_* is a plain write port
// (index 0 half_period_ticks, index 1 max_pulses), which the user must write
// only while idle; the block itself does not enforce this. A request passes the
// tick register, then the result register. Throughput: one request per cycle while
// out_ready is high; the step logic between the two registers is a single pass per tick.
// Reset (rst_n low, synchronous): sequence idle, timer and pulse count zero,
// registers back to 5 ticks and 16 pulses, both pipeline stages empty.
// Receiver stall: the result register holds; the tick register still takes
// one more request, then in_ready drops until out_ready returns. The
// sequence advances only when a tick moves into the result register, so
// stalls never lose or repeat a tick.
`timescale 1ns / 1ps
module i2c_bus_clear_sequencer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_start_req,
  input  logic                              in_scl_level,
  input  logic                              in_sda_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_scl_release,
  output logic                              out_sda_release,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic [i2cbc_pkg::STAT_W-1:0]      out_status,
  output logic [i2cbc_pkg::PULSE_W-1:0]     out_pulses_sent,
  input  logic                              cfg_we,
  input  logic [i2cbc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [i2cbc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import i2cbc_pkg::*;

  logic               tick_vld_r;
  logic               tick_start_r;
  logic               tick_scl_r;
  logic               tick_sda_r;
  logic               out_vld_r;
  seq_res_t           res_r;
  seq_state_t         state_r;
  seq_state_t         state_nxt;
  seq_res_t           res_nxt;
  logic [HALF_W-1:0]  half_period_r;
  logic [PULSE_W-1:0] max_pulses_r;
  logic               advance;

  // A tick moves on when the result register is free or being drained
  assign advance  = tick_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !tick_vld_r || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      max_pulses_r  <= MAX_PULSES_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_HALF_PERIOD: half_period_r <= cfg_wdata[HALF_W-1:0];
        CFG_MAX_PULSES:  max_pulses_r  <= cfg_wdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r <= 1'b0;
    end else if (in_ready) begin
      tick_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tick_start_r <= in_start_req;
      tick_scl_r   <= in_scl_level;
      tick_sda_r   <= in_sda_level;
    end
  end

  i2cbc_step u_step (
    .cur               (state_r),
    .start_req         (tick_start_r),
    .scl_level         (tick_scl_r),
    .sda_level         (tick_sda_r),
    .half_period_ticks (half_period_r),
    .max_pulses        (max_pulses_r),
    .nxt               (state_nxt),
    .res               (res_nxt)
  );

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, timer: '0, count: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_scl_release = res_r.scl_release;
  assign out_sda_release = res_r.sda_release;
  assign out_busy_res    = res_r.busy_res;
  assign out_done_res    = res_r.done_res;
  assign out_status      = res_r.status;
  assign out_pulses_sent = res_r.pulses_sent;

endmodule

// File: sv/i2cbc_checker.sv
// Port-level checks for the I2C bus-clear sequencer, bound to the top level.
`timescale 1ns / 1ps
module i2cbc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_scl_release,
  input logic                              out_sda_release,
  input logic                              out_busy_res,
  input logic                              out_done_res,
  input logic [i2cbc_pkg::STAT_W-1:0]      out_status,
  input logic [i2cbc_pkg::PULSE_W-1:0]     out_pulses_sent
);
  import i2cbc_pkg::*;

  // Pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The ending tick is never busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while busy");

  // Status only on the ending tick
  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_NONE) |-> out_done_res)
    else $error("status outside done tick");

  // Lines released whenever idle
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_scl_release && out_sda_release)
    else $error("line driven while idle");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulses_sent) &&
      $stable(out_status) && $stable(out_done_res))
    else $error("stalled result changed");

endmodule

bind i2c_bus_clear_sequencer_core i2cbc_checker u_i2cbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_scl_release (out_scl_release),
  .out_sda_release (out_sda_release),
  .out_busy_res    (out_busy_res),
  .out_done_res    (out_done_res),
  .out_status      (out_status),
  .out_pulses_sent (out_pulses_sent)
);
